>>> sv/sfm_pkg.sv
package sfm_pkg;

  localparam int unsigned MaxChannelsDefault = 32;

  localparam int unsigned InDataW  = 72;
  localparam int unsigned OutDataW = 72;
  localparam int unsigned ActW     = 2;
  localparam int unsigned StatusW  = 4;
  localparam int unsigned ChanW    = 5;

  localparam int unsigned ApbAddrW = 5;
  localparam int unsigned ApbDataW = 32;
  localparam int unsigned RegIdxW  = 3;

  localparam int unsigned DivSteps = 16;
  localparam int unsigned DivCntW  = $clog2(DivSteps);

  localparam logic [15:0] Magic16 = 16'd18458;
  localparam logic [15:0] Magic32 = 16'd29569;

  localparam logic [5:0] ChanLimit16 = 6'd16;
  localparam logic [5:0] ChanLimit32 = 6'd32;

  localparam logic [15:0]        TimeoutLimitRst = 16'd10;
  localparam logic [15:0]        ServoMinRst     = 16'd1000;
  localparam logic [15:0]        ServoMaxRst     = 16'd2000;
  localparam logic signed [31:0] MultiplierRst   = 32'sd65536;
  localparam logic signed [31:0] OffsetRst       = 32'sd0;

  localparam logic [RegIdxW-1:0] RegHave32     = 3'd0;
  localparam logic [RegIdxW-1:0] RegTimeout    = 3'd1;
  localparam logic [RegIdxW-1:0] RegServoMin   = 3'd2;
  localparam logic [RegIdxW-1:0] RegServoMax   = 3'd3;
  localparam logic [RegIdxW-1:0] RegMultiplier = 3'd4;
  localparam logic [RegIdxW-1:0] RegOffset     = 3'd5;

  localparam logic [ActW-1:0] ActTimeout = 2'd0;
  localparam logic [ActW-1:0] ActHeader  = 2'd1;
  localparam logic [ActW-1:0] ActPwm     = 2'd2;

  localparam logic [StatusW-1:0] StMiss     = 4'd0;
  localparam logic [StatusW-1:0] StLost     = 4'd1;
  localparam logic [StatusW-1:0] StBadMagic = 4'd2;
  localparam logic [StatusW-1:0] StDup      = 4'd3;
  localparam logic [StatusW-1:0] StInOrder  = 4'd4;
  localparam logic [StatusW-1:0] StSkipped  = 4'd5;
  localparam logic [StatusW-1:0] StRollback = 4'd6;
  localparam logic [StatusW-1:0] StCommand  = 4'd7;
  localparam logic [StatusW-1:0] StBadChan  = 4'd8;
  localparam logic [StatusW-1:0] StDropped  = 4'd9;

  typedef struct packed {
    logic               mode_32ch;
    logic [15:0]        timeout_limit;
    logic [15:0]        pwm_min;
    logic [15:0]        pwm_max;
    logic signed [31:0] multiplier;
    logic signed [31:0] offset;
  } cfg_t;

  typedef struct packed {
    logic accept;
    logic div_step;
    logic sum_en;
    logic mlo_en;
    logic mhi_en;
    logic sat_en;
    logic push;
  } ctrl_cmd_t;

  typedef struct packed {
    logic need_scale;
    logic out_free;
  } dp_stat_t;

endpackage

>>> sv/sfm_regs.sv
module sfm_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [sfm_pkg::ApbAddrW-1:0]   paddr,
  input  logic [sfm_pkg::ApbDataW-1:0]   pwdata,
  output logic [sfm_pkg::ApbDataW-1:0]   prdata,
  output logic                           pready,
  output sfm_pkg::cfg_t                  cfg_o
);

  sfm_pkg::cfg_t cfg_q, cfg_d;
  logic [sfm_pkg::RegIdxW-1:0] idx;
  logic wr_en;

  assign idx   = paddr[sfm_pkg::ApbAddrW-1:2];
  assign wr_en = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        sfm_pkg::RegHave32:     cfg_d.mode_32ch     = pwdata[0];
        sfm_pkg::RegTimeout:    cfg_d.timeout_limit = pwdata[15:0];
        sfm_pkg::RegServoMin:   cfg_d.pwm_min       = pwdata[15:0];
        sfm_pkg::RegServoMax:   cfg_d.pwm_max       = pwdata[15:0];
        sfm_pkg::RegMultiplier: cfg_d.multiplier    = $signed(pwdata);
        sfm_pkg::RegOffset:     cfg_d.offset        = $signed(pwdata);
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      sfm_pkg::RegHave32:     prdata = {31'b0, cfg_q.mode_32ch};
      sfm_pkg::RegTimeout:    prdata = {16'b0, cfg_q.timeout_limit};
      sfm_pkg::RegServoMin:   prdata = {16'b0, cfg_q.pwm_min};
      sfm_pkg::RegServoMax:   prdata = {16'b0, cfg_q.pwm_max};
      sfm_pkg::RegMultiplier: prdata = cfg_q.multiplier;
      sfm_pkg::RegOffset:     prdata = cfg_q.offset;
      default:                prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode_32ch     <= 1'b0;
      cfg_q.timeout_limit <= sfm_pkg::TimeoutLimitRst;
      cfg_q.pwm_min       <= sfm_pkg::ServoMinRst;
      cfg_q.pwm_max       <= sfm_pkg::ServoMaxRst;
      cfg_q.multiplier    <= sfm_pkg::MultiplierRst;
      cfg_q.offset        <= sfm_pkg::OffsetRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

>>> sv/sfm_ctrl.sv
module sfm_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  sfm_pkg::dp_stat_t     stat_i,
  output sfm_pkg::ctrl_cmd_t    cmd_o
);

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_DIV  = 7'b0000010,
    ST_SUM  = 7'b0000100,
    ST_MLO  = 7'b0001000,
    ST_MHI  = 7'b0010000,
    ST_SAT  = 7'b0100000,
    ST_PUSH = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic [sfm_pkg::DivCntW-1:0] cnt_q, cnt_d;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          cnt_d        = '0;
          state_d      = stat_i.need_scale ? ST_DIV : ST_PUSH;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == sfm_pkg::DivCntW'(sfm_pkg::DivSteps - 1)) begin
          state_d = ST_SUM;
        end
      end
      ST_SUM: begin
        cmd_o.sum_en = 1'b1;
        state_d      = ST_MLO;
      end
      ST_MLO: begin
        cmd_o.mlo_en = 1'b1;
        state_d      = ST_MHI;
      end
      ST_MHI: begin
        cmd_o.mhi_en = 1'b1;
        state_d      = ST_SAT;
      end
      ST_SAT: begin
        cmd_o.sat_en = 1'b1;
        state_d      = ST_PUSH;
      end
      ST_PUSH: begin
        if (stat_i.out_free) begin
          cmd_o.push = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

>>> sv/sfm_dp.sv
module sfm_dp #(
  parameter int unsigned MaxChannels = sfm_pkg::MaxChannelsDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  sfm_pkg::cfg_t                  cfg_i,
  input  sfm_pkg::ctrl_cmd_t             cmd_i,
  output sfm_pkg::dp_stat_t              stat_o,
  input  logic [sfm_pkg::ActW-1:0]       in_user_i,
  input  logic [sfm_pkg::InDataW-1:0]    in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [sfm_pkg::StatusW-1:0]    out_user_o,
  output logic [sfm_pkg::OutDataW-1:0]   out_data_o
);

  localparam logic [5:0] MaxChan = 6'(MaxChannels);

  // input fields
  logic [15:0]              in_magic, in_rate, in_fc, in_pwm;
  logic [sfm_pkg::ChanW-1:0] in_ch;

  assign in_magic = in_data_i[15:0];
  assign in_rate  = in_data_i[31:16];
  assign in_fc    = in_data_i[47:32];
  assign in_ch    = in_data_i[52:48];
  assign in_pwm   = in_data_i[68:53];

  // link state
  logic        online_q, online_d;
  logic [15:0] miss_q, miss_d;
  logic [15:0] last_q, last_d;
  logic [15:0] rate_q, rate_d;
  logic        fok_q, fok_d;

  // pending result
  logic [sfm_pkg::StatusW-1:0] r_status_q, r_status_d;
  logic                        r_clr_q, r_clr_d;
  logic [sfm_pkg::ChanW-1:0]   r_ch_q, r_ch_d;
  logic [15:0]                 r_missed_q, r_missed_d;
  logic signed [31:0]          r_cmd_q;
  logic                        need_scale;

  // scaling datapath
  logic        raw_zero_q, raw_zero_d, raw_one_q, raw_one_d;
  logic [15:0] rem_q, dvs_q, quo_q;
  logic [16:0] rem2;
  logic        rem_ge;
  logic [16:0] raw17;
  logic signed [32:0] sum_q;
  logic signed [16:0] mul_b;
  logic signed [48:0] prod;
  logic signed [47:0] plo_q;
  logic signed [48:0] phi_q;
  logic signed [49:0] qsum;
  logic signed [31:0] qsat;

  // output register
  logic                        ov_q;
  logic [sfm_pkg::StatusW-1:0] o_status_q;
  logic                        o_online_q, o_clr_q;
  logic [sfm_pkg::ChanW-1:0]   o_ch_q;
  logic signed [31:0]          o_cmd_q;
  logic [15:0]                 o_missed_q, o_rate_q;

  always_comb begin
    logic [16:0] n;
    logic [15:0] want;
    logic [5:0]  lim;
    online_d   = online_q;
    miss_d     = miss_q;
    last_d     = last_q;
    rate_d     = rate_q;
    fok_d      = fok_q;
    r_status_d = sfm_pkg::StDropped;
    r_clr_d    = 1'b0;
    r_ch_d     = '0;
    r_missed_d = '0;
    need_scale = 1'b0;
    n    = {1'b0, miss_q} + 17'd1;
    want = cfg_i.mode_32ch ? sfm_pkg::Magic32 : sfm_pkg::Magic16;
    lim  = cfg_i.mode_32ch ? sfm_pkg::ChanLimit32 : sfm_pkg::ChanLimit16;
    case (in_user_i)
      sfm_pkg::ActTimeout: begin
        fok_d      = 1'b0;
        r_status_d = sfm_pkg::StMiss;
        if (online_q) begin
          if (n > {1'b0, cfg_i.timeout_limit}) begin
            miss_d     = '0;
            online_d   = 1'b0;
            r_status_d = sfm_pkg::StLost;
            r_clr_d    = 1'b1;
          end else begin
            miss_d = n[15:0];
          end
        end
      end
      sfm_pkg::ActHeader: begin
        if (in_magic != want) begin
          r_status_d = sfm_pkg::StBadMagic;
          fok_d      = 1'b0;
        end else begin
          online_d = 1'b1;
          rate_d   = in_rate;
          if (in_fc == last_q) begin
            r_status_d = sfm_pkg::StDup;
            fok_d      = 1'b0;
          end else begin
            if (in_fc == last_q + 16'd1) begin
              r_status_d = sfm_pkg::StInOrder;
            end else if (in_fc < last_q) begin
              r_status_d = sfm_pkg::StRollback;
            end else begin
              r_status_d = sfm_pkg::StSkipped;
            end
            if (r_status_d != sfm_pkg::StRollback) begin
              r_missed_d = in_fc - last_q - 16'd1;
            end
            last_d = in_fc;
            miss_d = '0;
            fok_d  = 1'b1;
          end
        end
      end
      sfm_pkg::ActPwm: begin
        r_ch_d = in_ch;
        if (!fok_q) begin
          r_status_d = sfm_pkg::StDropped;
        end else if ({1'b0, in_ch} >= lim || {1'b0, in_ch} >= MaxChan) begin
          r_status_d = sfm_pkg::StBadChan;
        end else begin
          r_status_d = sfm_pkg::StCommand;
          need_scale = 1'b1;
        end
      end
      default: r_status_d = sfm_pkg::StDropped;
    endcase
  end

  assign raw_zero_d = (cfg_i.pwm_max <= cfg_i.pwm_min) || (in_pwm <= cfg_i.pwm_min);
  assign raw_one_d  = (in_pwm >= cfg_i.pwm_max);

  // restoring divide, one quotient bit a cycle
  assign rem2   = {rem_q, 1'b0};
  assign rem_ge = (rem2 >= {1'b0, dvs_q});

  always_comb begin
    if (raw_zero_q) begin
      raw17 = '0;
    end else if (raw_one_q) begin
      raw17 = 17'h10000;
    end else begin
      raw17 = {1'b0, quo_q};
    end
  end

  // one shared 32x17 multiplier: low half then high half of the sum
  assign mul_b = cmd_i.mlo_en ? $signed({1'b0, sum_q[15:0]}) : $signed(sum_q[32:16]);
  assign prod  = $signed(cfg_i.multiplier) * mul_b;

  assign qsum = $signed({phi_q[48], phi_q}) + $signed({{18{plo_q[47]}}, plo_q[47:16]});

  always_comb begin
    if (qsum[49:31] == {19{qsum[49]}}) begin
      qsat = qsum[31:0];
    end else if (qsum[49]) begin
      qsat = 32'sh8000_0000;
    end else begin
      qsat = 32'sh7fff_ffff;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      online_q <= 1'b0;
      miss_q   <= '0;
      last_q   <= '0;
      rate_q   <= '0;
      fok_q    <= 1'b0;
    end else if (cmd_i.accept) begin
      online_q <= online_d;
      miss_q   <= miss_d;
      last_q   <= last_d;
      rate_q   <= rate_d;
      fok_q    <= fok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      r_status_q <= r_status_d;
      r_clr_q    <= r_clr_d;
      r_ch_q     <= r_ch_d;
      r_missed_q <= r_missed_d;
      r_cmd_q    <= '0;
      raw_zero_q <= raw_zero_d;
      raw_one_q  <= raw_one_d;
      rem_q      <= in_pwm - cfg_i.pwm_min;
      dvs_q      <= cfg_i.pwm_max - cfg_i.pwm_min;
      quo_q      <= '0;
    end
    if (cmd_i.div_step) begin
      rem_q <= rem_ge ? 16'(rem2 - {1'b0, dvs_q}) : rem2[15:0];
      quo_q <= {quo_q[14:0], rem_ge};
    end
    if (cmd_i.sum_en) begin
      sum_q <= $signed({16'b0, raw17}) + $signed({cfg_i.offset[31], cfg_i.offset});
    end
    if (cmd_i.mlo_en) begin
      plo_q <= prod[47:0];
    end
    if (cmd_i.mhi_en) begin
      phi_q <= prod;
    end
    if (cmd_i.sat_en) begin
      r_cmd_q <= qsat;
    end
  end

  assign stat_o.need_scale = need_scale;
  assign stat_o.out_free   = !ov_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (cmd_i.push) begin
      ov_q <= 1'b1;
    end else if (out_ready_i) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      o_status_q <= r_status_q;
      o_online_q <= online_q;
      o_clr_q    <= r_clr_q;
      o_ch_q     <= r_ch_q;
      o_cmd_q    <= r_cmd_q;
      o_missed_q <= r_missed_q;
      o_rate_q   <= rate_q;
    end
  end

  assign out_valid_o = ov_q;
  assign out_user_o  = o_status_q;
  assign out_data_o  = {1'b0, o_rate_q, o_missed_q, o_cmd_q, o_ch_q, o_clr_q, o_online_q};

endmodule

>>> sv/servo_frame_monitor_and_scaler.sv
// servo frame monitor and scaler
// input stream: one word per event (receive timeout, packet header or pwm
// channel word), event kind on s_axis_tuser. output stream: one result word
// per input word, status code on m_axis_tuser.
// headers are checked for the mode's magic and sequence; timeouts count
// misses and drop the link past timeout_limit, asking for a command clear.
// pwm words of an accepted frame are scaled to saturated signed q16.16
// commands; configuration goes through the apb port, and the user must write
// it only while the block is idle: the block itself does not enforce this.
// timeout, header and rejected pwm words skip scaling and go to the output register;
// a scaled pwm word first goes through the one-bit-per-cycle restoring
// divider, then sum, two passes through one shared 32x17 multiplier, and saturation.
// words are handled one at a time: a new word is taken only after the last
// one has been pushed into the output register.
// the output register holds a finished word while the receiver stalls; the
// next word is still taken and worked on, then waits until the register frees.
// reset puts the link offline, clears counters and loads register defaults.
module servo_frame_monitor_and_scaler #(
  parameter int unsigned MaxChannels = sfm_pkg::MaxChannelsDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // magic, rate, sequence, channel, pwm_value, zero pad
  input  logic [sfm_pkg::InDataW-1:0]    s_axis_tdata,
  // action
  input  logic [sfm_pkg::ActW-1:0]       s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // online, clear_commands, out_channel, command, missed_frames, rate_seen, zero pad
  output logic [sfm_pkg::OutDataW-1:0]   m_axis_tdata,
  // status
  output logic [sfm_pkg::StatusW-1:0]    m_axis_tuser,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [sfm_pkg::ApbAddrW-1:0]   paddr,
  input  logic [sfm_pkg::ApbDataW-1:0]   pwdata,
  output logic [sfm_pkg::ApbDataW-1:0]   prdata,
  output logic                           pready
);

  sfm_pkg::cfg_t      cfg;
  sfm_pkg::ctrl_cmd_t cmd;
  sfm_pkg::dp_stat_t  stat;

  sfm_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  sfm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  sfm_dp #(
    .MaxChannels (MaxChannels)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .in_user_i   (s_axis_tuser),
    .in_data_i   (s_axis_tdata),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_user_o  (m_axis_tuser),
    .out_data_o  (m_axis_tdata)
  );

endmodule
